// ----- rtl/cfrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Contour fill ratio check: shared definitions
// Widths, register codes and the record types passed between the front end,
// the contour queue and the ratio back end.
// ----------------------------------------------------------------------------
package cfrc_pkg;

	localparam int COORD_BITS = 12;
	localparam int PROD_BITS  = 2 * COORD_BITS;
	localparam int TERM_BITS  = PROD_BITS + 1;
	localparam int SUM_BITS   = 48;
	localparam int BOX_BITS   = COORD_BITS + 1;
	localparam int WH_BITS    = 2 * BOX_BITS + 1;
	localparam int RATIO_BITS = 10;
	localparam int AREA_BITS  = 26;
	localparam int OUT_BOX_BITS = 13;
	localparam int LHS_BITS   = AREA_BITS + RATIO_BITS;
	localparam int THR_BITS   = WH_BITS + RATIO_BITS;
	localparam int CMP_BITS   = (LHS_BITS > THR_BITS) ? LHS_BITS : THR_BITS;

	localparam logic [AREA_BITS-1:0]  AREA_CAP     = AREA_BITS'(33554432);
	localparam logic [RATIO_BITS-1:0] AREA_SCALE   = RATIO_BITS'(1000);
	localparam logic [RATIO_BITS-1:0] RATIO_LOW_RST  = RATIO_BITS'(430);
	localparam logic [RATIO_BITS-1:0] RATIO_HIGH_RST = RATIO_BITS'(570);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic {
		REG_RATIO_LOW  = 1'b0,
		REG_RATIO_HIGH = 1'b1
	} reg_index_t;

	typedef logic [COORD_BITS-1:0] coord_t;

	// One closed contour, waiting for the ratio test.
	typedef struct packed {
		logic [SUM_BITS-1:0] sum;
		logic [BOX_BITS-1:0] width;
		logic [BOX_BITS-1:0] height;
	} contour_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic [RATIO_BITS-1:0] ratio_low;
		logic [RATIO_BITS-1:0] ratio_high;
	} ratio_cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MAG,
		BK_MUL,
		BK_THR,
		BK_CMP
	} back_state_t;

endpackage

// ----- rtl/contour_fill_ratio_check.sv -----
// ----------------------------------------------------------------------------
// Contour fill ratio check: top level
// Measures the doubled area and inclusive bounding box of a closed contour
// and tests area / box against a programmable fill ratio window.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------------------
//  input    | in_valid/in_stall  | point_x, point_y, last_point
//  output   | out_valid/out_stall| in_range, doubled_area, box_width/height
//  config   | APB write/read     | ratio_low at 0x0, ratio_high at 0x4
//
// The front end takes one vertex per cycle while in_stall is low; a closed
// contour passes its s1 and s2 registers before it reaches the queue. The
// back end takes one contour at a time through its IDLE, MAG, MUL, THR and
// CMP states, holding in CMP while its result is stalled; a four-entry
// queue absorbs bursts. in_stall rises only when a finished contour finds
// the queue full. Reset clears all control state, no clearing pass.
// ----------------------------------------------------------------------------
module contour_fill_ratio_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cfrc_pkg::COORD_BITS-1:0]     point_x,
	input  logic [cfrc_pkg::COORD_BITS-1:0]     point_y,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                in_range,
	output logic [cfrc_pkg::AREA_BITS-1:0]      doubled_area,
	output logic [cfrc_pkg::OUT_BOX_BITS-1:0]   box_width,
	output logic [cfrc_pkg::OUT_BOX_BITS-1:0]   box_height,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cfrc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [cfrc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [cfrc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready
);
	import cfrc_pkg::*;

	ratio_cfg_t    cfg_q;
	queue_status_t q_status;
	contour_rec_t  push_rec, head_rec;
	logic          q_push, q_pop;
	reg_index_t    reg_sel;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			REG_RATIO_LOW:  prdata = APB_DATA_BITS'(cfg_q.ratio_low);
			REG_RATIO_HIGH: prdata = APB_DATA_BITS'(cfg_q.ratio_high);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio_low  <= RATIO_LOW_RST;
			cfg_q.ratio_high <= RATIO_HIGH_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_RATIO_LOW:  cfg_q.ratio_low  <= pwdata[RATIO_BITS-1:0];
				REG_RATIO_HIGH: cfg_q.ratio_high <= pwdata[RATIO_BITS-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	cfrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point),
		.q_status   (q_status),
		.q_push     (q_push),
		.q_rec      (push_rec)
	);

	cfrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.pop      (q_pop),
		.head_rec (head_rec),
		.status   (q_status)
	);

	cfrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_status     (q_status),
		.q_rec        (head_rec),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.in_range     (in_range),
		.doubled_area (doubled_area),
		.box_width    (box_width),
		.box_height   (box_height)
	);

endmodule

// ----- rtl/cfrc_front.sv -----
// ----------------------------------------------------------------------------
// Contour fill ratio check: vertex front end
// Takes one vertex per cycle unless stalled, tracks the first and previous
// vertex and bounding box, and accumulates the shoelace sum in a pipeline.
// ----------------------------------------------------------------------------
module cfrc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  cfrc_pkg::coord_t       point_x,
	input  cfrc_pkg::coord_t       point_y,
	input  logic                   last_point,
	input  cfrc_pkg::queue_status_t q_status,
	output logic                   q_push,
	output cfrc_pkg::contour_rec_t q_rec
);
	import cfrc_pkg::*;

	coord_t first_x_q, first_y_q, prev_x_q, prev_y_q;
	coord_t min_x_q, max_x_q, min_y_q, max_y_q;
	logic   started_q;
	logic [SUM_BITS-1:0] sum_q;

	logic                 v_s1, last_s1, open_s1;
	logic [PROD_BITS-1:0] pa_s1, pb_s1, pc_s1, pd_s1;

	logic                 v_s2;
	logic [TERM_BITS-1:0] tc_s2;
	logic [BOX_BITS-1:0]  w_s2, h_s2;

	logic                 advance, accept, open;
	coord_t               fx, fy;
	logic [TERM_BITS-1:0] te, tc;
	logic [SUM_BITS-1:0]  base;

	// Only a finished contour can block, when the queue has no room for it.
	assign advance  = !(v_s2 && q_status.full);
	assign in_stall = !advance;
	assign accept   = in_valid && advance;
	assign open     = !started_q;
	assign fx       = open ? point_x : first_x_q;
	assign fy       = open ? point_y : first_y_q;

	assign te   = TERM_BITS'(pa_s1) - TERM_BITS'(pb_s1);
	assign tc   = TERM_BITS'(pc_s1) - TERM_BITS'(pd_s1);
	assign base = open_s1 ? '0 : sum_q;

	assign q_push       = v_s2 && !q_status.full;
	assign q_rec.sum    = sum_q + {{(SUM_BITS-TERM_BITS){tc_s2[TERM_BITS-1]}}, tc_s2};
	assign q_rec.width  = w_s2;
	assign q_rec.height = h_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			sum_q     <= '0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1 && last_s1;
			if (accept) begin
				started_q <= !last_point;
			end
			if (v_s1) begin
				// An opening vertex starts the sum from zero and adds no edge.
				sum_q <= open_s1 ? base :
					base + {{(SUM_BITS-TERM_BITS){te[TERM_BITS-1]}}, te};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pa_s1   <= PROD_BITS'(prev_x_q) * PROD_BITS'(point_y);
			pb_s1   <= PROD_BITS'(point_x) * PROD_BITS'(prev_y_q);
			pc_s1   <= PROD_BITS'(point_x) * PROD_BITS'(fy);
			pd_s1   <= PROD_BITS'(fx) * PROD_BITS'(point_y);
			last_s1 <= last_point;
			open_s1 <= open;
			prev_x_q <= point_x;
			prev_y_q <= point_y;
			first_x_q <= fx;
			first_y_q <= fy;
			if (open) begin
				min_x_q <= point_x;
				max_x_q <= point_x;
				min_y_q <= point_y;
				max_y_q <= point_y;
			end else begin
				if (point_x < min_x_q) min_x_q <= point_x;
				if (point_x > max_x_q) max_x_q <= point_x;
				if (point_y < min_y_q) min_y_q <= point_y;
				if (point_y > max_y_q) max_y_q <= point_y;
			end
		end
		if (advance && v_s1) begin
			tc_s2 <= tc;
			w_s2  <= BOX_BITS'(max_x_q) - BOX_BITS'(min_x_q) + BOX_BITS'(1);
			h_s2  <= BOX_BITS'(max_y_q) - BOX_BITS'(min_y_q) + BOX_BITS'(1);
		end
	end

endmodule

// ----- rtl/cfrc_queue.sv -----
// ----------------------------------------------------------------------------
// Contour fill ratio check: contour queue
// Small first-in first-out buffer of closed contours between the front end
// and the ratio back end.
// ----------------------------------------------------------------------------
module cfrc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  cfrc_pkg::contour_rec_t  push_rec,
	input  logic                    pop,
	output cfrc_pkg::contour_rec_t  head_rec,
	output cfrc_pkg::queue_status_t status
);
	import cfrc_pkg::*;

	contour_rec_t           slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]     count_q;

	assign status.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_rec     = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_BITS+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_BITS+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_rec;
	end

endmodule

// ----- rtl/cfrc_back.sv -----
// ----------------------------------------------------------------------------
// Contour fill ratio check: ratio back end
// Takes one closed contour at a time, forms the saturated doubled area and
// tests the fill ratio by cross-multiplication, then holds the result.
// ----------------------------------------------------------------------------
module cfrc_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfrc_pkg::ratio_cfg_t    cfg,
	input  cfrc_pkg::queue_status_t q_status,
	input  cfrc_pkg::contour_rec_t  q_rec,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    in_range,
	output logic [cfrc_pkg::AREA_BITS-1:0]    doubled_area,
	output logic [cfrc_pkg::OUT_BOX_BITS-1:0] box_width,
	output logic [cfrc_pkg::OUT_BOX_BITS-1:0] box_height
);
	import cfrc_pkg::*;

	back_state_t state_q, state_d;
	logic        load, finish;

	contour_rec_t          rec_q;
	logic [AREA_BITS-1:0]  area_q;
	logic [LHS_BITS-1:0]   lhs_q;
	logic [WH_BITS-1:0]    box_q;
	logic [THR_BITS-1:0]   lo_q, hi_q;
	logic                  out_valid_q;

	logic [SUM_BITS-1:0]   mag;
	logic [2*BOX_BITS-1:0] wh;
	logic                  ok;

	assign mag = rec_q.sum[SUM_BITS-1] ? (~rec_q.sum + SUM_BITS'(1)) : rec_q.sum;
	assign wh  = (2*BOX_BITS)'(rec_q.width) * (2*BOX_BITS)'(rec_q.height);
	assign ok  = (CMP_BITS'(lhs_q) >= CMP_BITS'(lo_q)) &&
		(CMP_BITS'(lhs_q) <= CMP_BITS'(hi_q));

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					load    = 1'b1;
					state_d = BK_MAG;
				end
			end
			BK_MAG: state_d = BK_MUL;
			BK_MUL: state_d = BK_THR;
			BK_THR: state_d = BK_CMP;
			BK_CMP: begin
				// The result register frees up when its transaction completes.
				if (!out_valid_q || !out_stall) begin
					finish  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign q_pop     = load;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) rec_q <= q_rec;
		if (state_q == BK_MAG) begin
			area_q <= (mag > SUM_BITS'(AREA_CAP)) ? AREA_CAP : AREA_BITS'(mag);
		end
		if (state_q == BK_MUL) begin
			lhs_q <= LHS_BITS'(area_q) * LHS_BITS'(AREA_SCALE);
			box_q <= {wh, 1'b0};
		end
		if (state_q == BK_THR) begin
			lo_q <= THR_BITS'(cfg.ratio_low) * THR_BITS'(box_q);
			hi_q <= THR_BITS'(cfg.ratio_high) * THR_BITS'(box_q);
		end
		if (finish) begin
			in_range     <= ok;
			doubled_area <= area_q;
			box_width    <= OUT_BOX_BITS'(rec_q.width);
			box_height   <= OUT_BOX_BITS'(rec_q.height);
		end
	end

endmodule

// ----- rtl/cfrc_checker.sv -----
// ----------------------------------------------------------------------------
// Contour fill ratio check: port checker
// Watches the top level ports for result holding, area saturation, box
// extent and the configuration port handshake.
// ----------------------------------------------------------------------------
module cfrc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                in_range,
	input logic [cfrc_pkg::AREA_BITS-1:0]      doubled_area,
	input logic [cfrc_pkg::OUT_BOX_BITS-1:0]   box_width,
	input logic [cfrc_pkg::OUT_BOX_BITS-1:0]   box_height,
	input logic                                pready
);
	import cfrc_pkg::*;

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(in_range) &&
		$stable(doubled_area) && $stable(box_width) && $stable(box_height))
		else $error("result changed while stalled");

	// The doubled area never passes the saturation cap.
	a_area_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> doubled_area <= AREA_CAP)
		else $error("doubled area above saturation cap");

	// An inclusive box always covers at least one pixel each way.
	a_box_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> box_width != '0 && box_height != '0)
		else $error("empty bounding box reported");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind contour_fill_ratio_check cfrc_checker u_cfrc_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Contour fill ratio check: testbench
// Streams contour vertices into the block, predicts every contour measurement
// (doubled area, inclusive box, fill ratio window test) and compares each
// result transaction in order, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

	import cfrc_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int VERTEX_TARGET = 950;
	localparam int DRAIN_CYCLES  = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_COORD     = (1 << COORD_BITS) - 1;

	typedef struct packed {
		logic                    in_range;
		logic [AREA_BITS-1:0]    doubled_area;
		logic [OUT_BOX_BITS-1:0] box_width;
		logic [OUT_BOX_BITS-1:0] box_height;
	} contour_result_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	coord_t                   point_x = '0;
	coord_t                   point_y = '0;
	logic                     last_point = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     in_range;
	logic [AREA_BITS-1:0]     doubled_area;
	logic [OUT_BOX_BITS-1:0]  box_width;
	logic [OUT_BOX_BITS-1:0]  box_height;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	// Predicted block state.
	logic [RATIO_BITS-1:0] window_low = RATIO_LOW_RST;
	logic [RATIO_BITS-1:0] window_high = RATIO_HIGH_RST;
	coord_t                start_x = '0, start_y = '0, trail_x = '0, trail_y = '0;
	coord_t                lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0;
	logic [SUM_BITS-1:0]   shoelace_acc = '0;
	bit                    contour_open = 1'b0;

	contour_result_t pending_contours[$];
	vertex_t         outline[$];

	int  vertex_count = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  result_wait = 0;
	int  hold_len = 0;
	bit  hold_active = 1'b0;
	bit  idle_on = 1'b1;
	bit  offering = 1'b0;

	contour_fill_ratio_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.in_range     (in_range),
		.doubled_area (doubled_area),
		.box_width    (box_width),
		.box_height   (box_height),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic logic [SUM_BITS-1:0] cross_term(coord_t ax, coord_t ay,
			coord_t bx, coord_t by);
		longint prod;
		prod = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
		return prod[SUM_BITS-1:0];
	endfunction

	// Advances the predicted contour by one vertex and queues the
	// measurement when the vertex closes the contour.
	function automatic void measure_vertex(coord_t x, coord_t y, bit closing);
		logic [SUM_BITS-1:0]  mag;
		logic [AREA_BITS-1:0] area;
		longint unsigned      w, h, box, lhs;
		contour_result_t      res;
		if (!contour_open) begin
			start_x = x; trail_x = x; lo_x = x; hi_x = x;
			start_y = y; trail_y = y; lo_y = y; hi_y = y;
			shoelace_acc = '0;
			contour_open = 1'b1;
		end else begin
			shoelace_acc = shoelace_acc + cross_term(trail_x, trail_y, x, y);
			if (x < lo_x) lo_x = x;
			if (x > hi_x) hi_x = x;
			if (y < lo_y) lo_y = y;
			if (y > hi_y) hi_y = y;
			trail_x = x;
			trail_y = y;
		end
		if (!closing)
			return;
		shoelace_acc = shoelace_acc + cross_term(x, y, start_x, start_y);
		mag = shoelace_acc[SUM_BITS-1] ? (~shoelace_acc + 1'b1) : shoelace_acc;
		area = (mag > AREA_CAP) ? AREA_CAP : mag[AREA_BITS-1:0];
		w = hi_x - lo_x + 1;
		h = hi_y - lo_y + 1;
		box = 2 * w * h;
		lhs = 64'd1000 * area;
		res.in_range = (lhs >= window_low * box) && (lhs <= window_high * box);
		res.doubled_area = area;
		res.box_width = w[OUT_BOX_BITS-1:0];
		res.box_height = h[OUT_BOX_BITS-1:0];
		pending_contours = {pending_contours, res};
		contour_open = 1'b0;
	endfunction

	// Receiver: a random stall after each result taken while idle_on is set, plus the long hold-off.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			result_wait = idle_on ? $urandom_range(0, 12) : 0;
		else if (result_wait != 0)
			result_wait = result_wait - 1;
		out_stall <= hold_active || (result_wait != 0);
	end

	initial begin : hold_receiver
		forever begin
			wait (hold_len != 0);
			hold_active <= 1'b1;
			repeat (hold_len) @(posedge clk);
			hold_active <= 1'b0;
			hold_len = 0;
		end
	end

	always @(posedge clk) begin : check_results
		contour_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_contours.size() == 0) begin
				report_mismatch("result transaction with none outstanding");
			end else begin
				want = pending_contours.pop_front();
				if (in_range !== want.in_range)
					report_mismatch($sformatf("in_range got %0d expected %0d",
						in_range, want.in_range));
				if (doubled_area !== want.doubled_area)
					report_mismatch($sformatf("doubled_area got %0d expected %0d",
						doubled_area, want.doubled_area));
				if (box_width !== want.box_width)
					report_mismatch($sformatf("box_width got %0d expected %0d",
						box_width, want.box_width));
				if (box_height !== want.box_height)
					report_mismatch($sformatf("box_height got %0d expected %0d",
						box_height, want.box_height));
			end
		end
	end

	task automatic drop_valid();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic send_vertex(coord_t x, coord_t y, bit closing);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			drop_valid();
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= closing;
		offering = 1'b1;
		do @(posedge clk); while (in_stall);
		measure_vertex(x, y, closing);
		vertex_count++;
	endtask

	// Waits until every predicted result has been taken, then lets the
	// block settle for the given number of cycles.
	task automatic wait_drained(int settle);
		drop_valid();
		while (pending_contours.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_ratio(reg_index_t idx, logic [RATIO_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_RATIO_LOW)
			window_low = value;
		else
			window_high = value;
		@(posedge clk);
	endtask

	task automatic read_ratio(reg_index_t idx);
		logic [RATIO_BITS-1:0] want;
		want = (idx == REG_RATIO_LOW) ? window_low : window_high;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== APB_DATA_BITS'(want))
			report_mismatch($sformatf("register %s read %0d expected %0d",
				idx.name(), prdata, want));
		@(posedge clk);
	endtask

	task automatic set_window(logic [RATIO_BITS-1:0] low, logic [RATIO_BITS-1:0] high);
		write_ratio(REG_RATIO_LOW, low);
		write_ratio(REG_RATIO_HIGH, high);
		read_ratio(REG_RATIO_LOW);
		read_ratio(REG_RATIO_HIGH);
	endtask

	function automatic void outline_add(int x, int y);
		vertex_t v;
		v.x = coord_t'(x);
		v.y = coord_t'(y);
		outline = {outline, v};
	endfunction

	function automatic int pick_span();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
			: $urandom_range(1, MAX_COORD);
	endfunction

	function automatic void frame_square();
		outline_add(0, 0);
		outline_add(MAX_COORD, 0);
		outline_add(MAX_COORD, MAX_COORD);
		outline_add(0, MAX_COORD);
	endfunction

	// A box with its corners cut; the cut sets the fill ratio between
	// roughly one half and one.
	function automatic void build_octagon();
		int w, h, c, x0, y0;
		w = pick_span();
		h = pick_span();
		c = $urandom_range(0, ((w < h) ? w : h) / 2);
		x0 = $urandom_range(0, MAX_COORD - w);
		y0 = $urandom_range(0, MAX_COORD - h);
		outline_add(x0 + c, y0);
		outline_add(x0 + w - c, y0);
		outline_add(x0 + w, y0 + c);
		outline_add(x0 + w, y0 + h - c);
		outline_add(x0 + w - c, y0 + h);
		outline_add(x0 + c, y0 + h);
		outline_add(x0, y0 + h - c);
		outline_add(x0, y0 + c);
	endfunction

	function automatic void build_triangle();
		int w, h, x0, y0;
		w = pick_span();
		h = pick_span();
		x0 = $urandom_range(0, MAX_COORD - w);
		y0 = $urandom_range(0, MAX_COORD - h);
		outline_add(x0, y0);
		outline_add(x0 + w, y0);
		outline_add(x0 + $urandom_range(0, w), y0 + h);
	endfunction

	function automatic void build_scatter();
		int n, span, x0, y0, k;
		n = $urandom_range(1, 12);
		span = pick_span();
		x0 = $urandom_range(0, MAX_COORD - span);
		y0 = $urandom_range(0, MAX_COORD - span);
		for (k = 0; k < n; k++)
			outline_add(x0 + $urandom_range(0, span), y0 + $urandom_range(0, span));
	endfunction

	// Sends the outline, optionally walked backwards and wound more than once.
	task automatic send_outline(bit reverse, int winds);
		int n, k, j, total;
		n = outline.size();
		total = winds * n;
		for (k = 0; k < total; k++) begin
			j = reverse ? n - 1 - (k % n) : k % n;
			send_vertex(outline[j].x, outline[j].y, k == total - 1);
		end
		outline.delete();
	endtask

	task automatic send_random_contour();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			build_octagon();
		else if (pick < 7)
			build_triangle();
		else
			build_scatter();
		send_outline($urandom_range(0, 1),
			($urandom_range(0, 15) == 0) ? $urandom_range(2, 3) : 1);
	endtask

	task automatic test_register_reset();
		read_ratio(REG_RATIO_LOW);
		read_ratio(REG_RATIO_HIGH);
	endtask

	task automatic test_directed_shapes();
		outline_add(0, 0);
		send_outline(1'b0, 1);
		frame_square();
		send_outline(1'b0, 1);
		frame_square();
		send_outline(1'b1, 1);
		// Wound twice, the area passes the saturation cap.
		frame_square();
		send_outline(1'b0, 2);
		outline_add(0, 0);
		outline_add(MAX_COORD, 0);
		outline_add(0, MAX_COORD);
		send_outline(1'b0, 1);
		outline_add(0, MAX_COORD);
		outline_add(MAX_COORD, 0);
		send_outline(1'b0, 1);
		// A lone vertex only passes when the lower bound is zero.
		wait_drained(DRAIN_CYCLES);
		set_window(0, RATIO_HIGH_RST);
		outline_add(MAX_COORD, MAX_COORD);
		send_outline(1'b0, 1);
		wait_drained(DRAIN_CYCLES);
	endtask

	task automatic test_window_sweep();
		logic [RATIO_BITS-1:0] lows[9];
		logic [RATIO_BITS-1:0] highs[9];
		int k, phase_end;
		lows = '{430, 410, 700, 0, 0, 1023, 1023, 1000, 0};
		highs = '{570, 500, 800, 0, 1023, 1023, 0, 1000, 0};
		lows[8] = $urandom_range(0, 1023);
		highs[8] = $urandom_range(0, 1023);
		for (k = 0; k < 9; k++) begin
			wait_drained(DRAIN_CYCLES);
			set_window(lows[k], highs[k]);
			idle_on = (k % 3 != 0);
			phase_end = vertex_count + 25;
			while (vertex_count < phase_end)
				send_random_contour();
		end
		idle_on = 1'b1;
	endtask

	// Short contours back to back while the receiver holds off, so the
	// contour queue fills and the input stalls.
	task automatic test_output_backpressure();
		int k;
		wait_drained(DRAIN_CYCLES);
		idle_on = 1'b0;
		hold_len = HOLD_CYCLES;
		for (k = 0; k < 30; k++) begin
			if (k % 3 == 2)
				build_triangle();
			else
				outline_add($urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD));
			send_outline(k % 2, 1);
		end
		wait_drained(0);
		idle_on = 1'b1;
	endtask

	task automatic test_random_contours();
		wait_drained(DRAIN_CYCLES);
		set_window(700, 800);
		while (vertex_count < VERTEX_TARGET) begin
			if ($urandom_range(0, 19) == 0)
				idle_on = !idle_on;
			if ($urandom_range(0, 29) == 0)
				wait_drained(0);
			send_random_contour();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_shapes();
		test_window_sweep();
		test_output_backpressure();
		test_random_contours();
		wait_drained(DRAIN_CYCLES);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
